FILE: rtl/bsa_pkg.sv
// Shared types, codes and defaults for the block slot allocator.
package bsa_pkg;

    localparam int MAX_SLOTS_DEF      = 256;
    localparam int MAX_RUN_BLOCKS_DEF = 16;
    localparam int FREE_PER_SIZE_DEF  = 32;

    localparam int REC_HDR = 4;

    localparam logic [14:0] BLOCK_SIZE_RST = 15'd128;
    localparam logic [15:0] HEADER_RST     = 16'd16;

    localparam logic CFG_BLOCK_SIZE = 1'b0;
    localparam logic CFG_HEADER     = 1'b1;

    localparam logic [2:0] OP_RESTART = 3'd0;
    localparam logic [2:0] OP_SCAN    = 3'd1;
    localparam logic [2:0] OP_OPEN    = 3'd2;
    localparam logic [2:0] OP_PUT     = 3'd3;
    localparam logic [2:0] OP_CLEAR   = 3'd4;

    localparam logic [2:0] STAT_OK         = 3'd0;
    localparam logic [2:0] STAT_NOT_FOUND  = 3'd1;
    localparam logic [2:0] STAT_TABLE_FULL = 3'd2;
    localparam logic [2:0] STAT_LIST_FULL  = 3'd3;
    localparam logic [2:0] STAT_TOO_LONG   = 3'd4;

    // list select is wide enough for the largest run bound
    localparam int FL_LST_W = 6;

    typedef enum logic [2:0] {
        ST_CLR,
        ST_IDLE,
        ST_DIV,
        ST_RD,
        ST_DECIDE,
        ST_ALLOC,
        ST_MUL,
        ST_ADD
    } t_state;

    typedef struct packed {
        logic                push;
        logic [FL_LST_W-1:0] push_lst;
        logic [15:0]         push_blk;
        logic                pop;
        logic [FL_LST_W-1:0] pop_lst;
    } t_fl_req;

    typedef struct packed {
        logic push_full;
        logic pop_empty;
    } t_fl_stat;

endpackage

FILE: rtl/block_slot_allocator_top.sv
// Block slot allocator: command port, config port and the control sequencer.
//
// Usage: drive i_opcode and its operands with i_start while o_busy is low; the
// item is taken at that edge. Exactly one result follows per item, shown for
// one cycle with o_valid; the receiver cannot hold it off, so it must sample
// every o_valid cycle.
// Scan, open-for-append and put run the shared restoring divider (one quotient
// bit per cycle); after the done handoff come slot read, decide, multiply and
// offset add, and o_valid rises after the offset add; a put that takes a run
// from its list or appends one at the end also passes the allocate state.
// Restart, clear and unused codes skip the divider and go straight to slot read.
// One item is in flight at a time; o_busy stays high until the result issues,
// and a new item may be started in the cycle that o_valid is high.
// Slot state lives in a synchronous slot memory; free runs live in a per-size
// FIFO memory. Every change is read, modified and written back in sequence.
// After reset the slot memory is swept clear, one entry per cycle, over all
// MAX_SLOTS entries with o_busy high; config writes are taken at any time
// but belong only where no item is in flight.
module block_slot_allocator_top #(
    parameter int MAX_SLOTS      = bsa_pkg::MAX_SLOTS_DEF,
    parameter int MAX_RUN_BLOCKS = bsa_pkg::MAX_RUN_BLOCKS_DEF,
    parameter int FREE_PER_SIZE  = bsa_pkg::FREE_PER_SIZE_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic [2:0]         i_opcode,
    input  logic               i_index_given,
    input  logic [7:0]         i_slot_index,
    input  logic signed [15:0] i_length,
    input  logic [31:0]        i_file_size,
    input  logic               i_cfg_we,
    input  logic               i_cfg_addr,
    input  logic [15:0]        i_cfg_data,
    output logic               o_valid,
    output logic [2:0]         o_status,
    output logic [7:0]         o_out_index,
    output logic [15:0]        o_block_number,
    output logic [4:0]         o_block_count,
    output logic [31:0]        o_byte_offset,
    output logic [13:0]        o_pad_bytes,
    output logic               o_freed_valid,
    output logic [15:0]        o_freed_block,
    output logic [4:0]         o_freed_count
);

    localparam int SAW = $clog2(MAX_SLOTS);
    localparam int NSW = $clog2(MAX_SLOTS + 1);
    localparam int BCW = $clog2(MAX_RUN_BLOCKS + 1);
    localparam int SDW = 17 + BCW;
    localparam int LSW = bsa_pkg::FL_LST_W;

    bsa_pkg::t_state r_state, n_state;

    logic [2:0]         r_op;
    logic               r_given;
    logic [7:0]         r_idx;
    logic signed [15:0] r_len;
    logic [NSW-1:0]     r_next_slot, n_next_slot;
    logic [15:0]        r_scan, n_scan;
    logic [15:0]        r_end, n_end;
    logic [14:0]        r_block_size;
    logic [15:0]        r_header;
    logic [SAW-1:0]     r_clr_cnt;
    logic [SAW-1:0]     r_wslot, n_wslot;
    logic [2:0]         r_status, n_status;
    logic [7:0]         r_out_idx, n_out_idx;
    logic [15:0]        r_blk, n_blk;
    logic [BCW-1:0]     r_cnt, n_cnt;
    logic [13:0]        r_pad, n_pad;
    logic               r_fv, n_fv;
    logic [15:0]        r_fblk, n_fblk;
    logic [BCW-1:0]     r_fcnt, n_fcnt;
    logic               r_off_en, n_off_en;
    logic [30:0]        r_prod, n_prod;
    logic [31:0]        r_offset, n_offset;
    logic               r_valid, n_valid;

    logic               accept;
    logic [14:0]        bsz;
    logic               div_start;
    logic [31:0]        dividend;
    logic               div_done;
    logic [31:0]        div_quo;
    logic [14:0]        div_rem;

    logic               slot_we;
    logic [SAW-1:0]     slot_waddr;
    logic [SDW-1:0]     slot_wdata;
    logic [SDW-1:0]     slot_rdata;
    logic               sd_valid;
    logic [15:0]        sd_start;
    logic [BCW-1:0]     sd_blocks;
    logic               sd_ok;

    bsa_pkg::t_fl_req   fl_req;
    bsa_pkg::t_fl_stat  fl_stat;
    logic [15:0]        fl_q;

    logic [16:0]        cnt17;
    logic [BCW-1:0]     cnt_b;
    logic               too_long;
    logic [16:0]        neg17;
    logic               neg_long;
    logic [15:0]        rem1;
    logic [15:0]        pad_full;
    logic [15:0]        end_sat;
    logic               ns_full;
    logic [NSW-1:0]     ns_inc;
    logic               len_zero;
    logic               do_clear;
    logic [15:0]        blk_new;

    assign accept = i_start && !o_busy;
    assign bsz    = (r_block_size == '0) ? 15'd1 : r_block_size;

    assign dividend = (i_opcode == bsa_pkg::OP_OPEN) ?
                      ((i_file_size >= 32'(r_header)) ? i_file_size - 32'(r_header) : '0) :
                      {16'd0, $unsigned(i_length) + 16'(bsa_pkg::REC_HDR - 1)};

    bsa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dividend),
        .i_divisor  (bsz),
        .o_done     (div_done),
        .o_quo      (div_quo),
        .o_rem      (div_rem)
    );

    bsa_slot_ram #(
        .AW (SAW),
        .DW (SDW)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (slot_waddr),
        .i_wdata (slot_wdata),
        .i_raddr (SAW'(r_idx)),
        .o_rdata (slot_rdata)
    );

    bsa_free_list #(
        .MAX_RUN_BLOCKS (MAX_RUN_BLOCKS),
        .FREE_PER_SIZE  (FREE_PER_SIZE)
    ) u_free_list (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (fl_req),
        .o_stat    (fl_stat),
        .o_pop_blk (fl_q)
    );

    assign sd_valid  = slot_rdata[SDW-1];
    assign sd_start  = slot_rdata[SDW-2 -: 16];
    assign sd_blocks = slot_rdata[BCW-1:0];
    assign sd_ok     = (32'(r_idx) < MAX_SLOTS) && sd_valid;

    assign cnt17    = div_quo[16:0] + 17'd1;
    assign cnt_b    = BCW'(cnt17);
    assign too_long = cnt17 > 17'(MAX_RUN_BLOCKS);
    assign neg17    = 17'(~{r_len[15], r_len} + 17'd1);
    assign neg_long = neg17 > 17'(MAX_RUN_BLOCKS);
    // remainder of (len + 4) follows from that of (len + 3)
    assign rem1     = {1'b0, div_rem} + 16'd1;
    assign pad_full = (rem1 == {1'b0, bsz}) ? 16'd0 : {1'b0, bsz} - rem1;
    assign end_sat  = (div_quo > 32'h0000_FFFF) ? 16'hFFFF : div_quo[15:0];
    assign ns_full  = r_next_slot >= NSW'(MAX_SLOTS);
    assign ns_inc   = r_next_slot + NSW'(1);
    assign len_zero = r_len == '0;
    assign do_clear = (r_op == bsa_pkg::OP_CLEAR) || (len_zero && r_given);

    always_comb begin
        n_state     = r_state;
        n_next_slot = r_next_slot;
        n_scan      = r_scan;
        n_end       = r_end;
        n_wslot     = r_wslot;
        n_status    = r_status;
        n_out_idx   = r_out_idx;
        n_blk       = r_blk;
        n_cnt       = r_cnt;
        n_pad       = r_pad;
        n_fv        = r_fv;
        n_fblk      = r_fblk;
        n_fcnt      = r_fcnt;
        n_off_en    = r_off_en;
        n_prod      = r_prod;
        n_offset    = r_offset;
        n_valid     = 1'b0;
        div_start   = 1'b0;
        slot_we     = 1'b0;
        slot_waddr  = r_clr_cnt;
        slot_wdata  = '0;
        blk_new     = r_end;
        fl_req.push     = 1'b0;
        fl_req.push_lst = '0;
        fl_req.push_blk = '0;
        fl_req.pop      = 1'b0;
        fl_req.pop_lst  = LSW'(cnt17 - 17'd1);

        case (r_state)
            bsa_pkg::ST_CLR: begin
                slot_we = 1'b1;
                if (r_clr_cnt == SAW'(MAX_SLOTS - 1)) begin
                    n_state = bsa_pkg::ST_IDLE;
                end
            end
            bsa_pkg::ST_IDLE: begin
                if (accept) begin
                    if (i_opcode == bsa_pkg::OP_SCAN || i_opcode == bsa_pkg::OP_OPEN ||
                        i_opcode == bsa_pkg::OP_PUT) begin
                        div_start = 1'b1;
                        n_state   = bsa_pkg::ST_DIV;
                    end else begin
                        n_state = bsa_pkg::ST_RD;
                    end
                end
            end
            bsa_pkg::ST_DIV: begin
                if (div_done) begin
                    n_state = bsa_pkg::ST_RD;
                end
            end
            bsa_pkg::ST_RD: begin
                n_state = bsa_pkg::ST_DECIDE;
            end
            bsa_pkg::ST_DECIDE: begin
                n_state   = bsa_pkg::ST_MUL;
                n_status  = bsa_pkg::STAT_OK;
                n_out_idx = '0;
                n_blk     = '0;
                n_cnt     = '0;
                n_pad     = '0;
                n_fv      = 1'b0;
                n_fblk    = '0;
                n_fcnt    = '0;
                n_off_en  = 1'b0;
                case (r_op)
                    bsa_pkg::OP_RESTART: begin
                        n_scan = '0;
                    end
                    bsa_pkg::OP_SCAN: begin
                        n_blk    = r_scan;
                        n_off_en = 1'b1;
                        if (!r_len[15]) begin
                            n_out_idx = 8'(r_next_slot);
                            n_pad     = pad_full[13:0];
                            n_scan    = r_scan + cnt17[15:0];
                            if (too_long) begin
                                n_status = bsa_pkg::STAT_TOO_LONG;
                                if (!ns_full) begin
                                    n_next_slot = ns_inc;
                                end
                            end else if (ns_full) begin
                                n_status = bsa_pkg::STAT_TABLE_FULL;
                                n_cnt    = cnt_b;
                            end else begin
                                slot_we     = 1'b1;
                                slot_waddr  = SAW'(r_next_slot);
                                slot_wdata  = {1'b1, r_scan, cnt_b};
                                n_next_slot = ns_inc;
                                n_cnt       = cnt_b;
                            end
                        end else begin
                            n_scan = r_scan + neg17[15:0];
                            if (neg_long) begin
                                n_status = bsa_pkg::STAT_TOO_LONG;
                            end else begin
                                n_cnt           = BCW'(neg17);
                                fl_req.push_lst = LSW'(neg17 - 17'd1);
                                fl_req.push_blk = r_scan;
                                if (fl_stat.push_full) begin
                                    n_status = bsa_pkg::STAT_LIST_FULL;
                                end else begin
                                    fl_req.push = 1'b1;
                                end
                            end
                        end
                    end
                    bsa_pkg::OP_OPEN: begin
                        n_end    = end_sat;
                        n_blk    = end_sat;
                        n_off_en = 1'b1;
                    end
                    bsa_pkg::OP_PUT, bsa_pkg::OP_CLEAR: begin
                        n_out_idx = r_idx;
                        if (do_clear) begin
                            fl_req.push_lst = LSW'(sd_blocks - BCW'(1));
                            fl_req.push_blk = sd_start;
                            if (!sd_ok) begin
                                n_status = bsa_pkg::STAT_NOT_FOUND;
                            end else if (fl_stat.push_full) begin
                                n_status = bsa_pkg::STAT_LIST_FULL;
                            end else begin
                                fl_req.push = 1'b1;
                                slot_we     = 1'b1;
                                slot_waddr  = SAW'(r_idx);
                                n_fv        = 1'b1;
                                n_fblk      = sd_start;
                                n_fcnt      = sd_blocks;
                                n_blk       = sd_start;
                                n_cnt       = sd_blocks;
                                n_off_en    = 1'b1;
                            end
                        end else if (len_zero) begin
                            n_status = bsa_pkg::STAT_NOT_FOUND;
                        end else if (r_len[15] || too_long) begin
                            n_status = bsa_pkg::STAT_TOO_LONG;
                        end else if (r_given) begin
                            fl_req.push_lst = LSW'(sd_blocks - BCW'(1));
                            fl_req.push_blk = sd_start;
                            if (!sd_ok) begin
                                n_status = bsa_pkg::STAT_NOT_FOUND;
                            end else if (sd_blocks == cnt_b) begin
                                // same size: keep the run in place
                                n_blk    = sd_start;
                                n_cnt    = cnt_b;
                                n_pad    = pad_full[13:0];
                                n_off_en = 1'b1;
                            end else if (fl_stat.push_full) begin
                                n_status = bsa_pkg::STAT_LIST_FULL;
                            end else begin
                                fl_req.push = 1'b1;
                                n_fv        = 1'b1;
                                n_fblk      = sd_start;
                                n_fcnt      = sd_blocks;
                                n_wslot     = SAW'(r_idx);
                                n_cnt       = cnt_b;
                                n_pad       = pad_full[13:0];
                                n_off_en    = 1'b1;
                                n_state     = bsa_pkg::ST_ALLOC;
                            end
                        end else if (ns_full) begin
                            n_status  = bsa_pkg::STAT_TABLE_FULL;
                            n_out_idx = 8'(r_next_slot);
                        end else begin
                            n_out_idx   = 8'(r_next_slot);
                            n_wslot     = SAW'(r_next_slot);
                            n_next_slot = ns_inc;
                            n_cnt       = cnt_b;
                            n_pad       = pad_full[13:0];
                            n_off_en    = 1'b1;
                            n_state     = bsa_pkg::ST_ALLOC;
                        end
                    end
                    default: ;
                endcase
            end
            bsa_pkg::ST_ALLOC: begin
                // take a run of this size from its list, else append at the end
                if (!fl_stat.pop_empty) begin
                    fl_req.pop = 1'b1;
                    blk_new    = fl_q;
                end else begin
                    n_end = r_end + 16'(r_cnt);
                end
                slot_we    = 1'b1;
                slot_waddr = r_wslot;
                slot_wdata = {1'b1, blk_new, r_cnt};
                n_blk      = blk_new;
                n_state    = bsa_pkg::ST_MUL;
            end
            bsa_pkg::ST_MUL: begin
                n_prod  = 31'(r_blk) * 31'(bsz);
                n_state = bsa_pkg::ST_ADD;
            end
            bsa_pkg::ST_ADD: begin
                n_offset = r_off_en ? 32'(r_header) + 32'(r_prod) : '0;
                n_valid  = 1'b1;
                n_state  = bsa_pkg::ST_IDLE;
            end
            default: begin
                n_state = bsa_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= bsa_pkg::ST_CLR;
            r_next_slot  <= '0;
            r_scan       <= '0;
            r_end        <= '0;
            r_block_size <= bsa_pkg::BLOCK_SIZE_RST;
            r_header     <= bsa_pkg::HEADER_RST;
            r_clr_cnt    <= '0;
            r_valid      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_next_slot <= n_next_slot;
            r_scan      <= n_scan;
            r_end       <= n_end;
            r_valid     <= n_valid;
            if (r_state == bsa_pkg::ST_CLR) begin
                r_clr_cnt <= r_clr_cnt + SAW'(1);
            end
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    bsa_pkg::CFG_BLOCK_SIZE: r_block_size <= i_cfg_data[14:0];
                    bsa_pkg::CFG_HEADER:     r_header     <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op    <= i_opcode;
            r_given <= i_index_given;
            r_idx   <= i_slot_index;
            r_len   <= i_length;
        end
        r_wslot   <= n_wslot;
        r_status  <= n_status;
        r_out_idx <= n_out_idx;
        r_blk     <= n_blk;
        r_cnt     <= n_cnt;
        r_pad     <= n_pad;
        r_fv      <= n_fv;
        r_fblk    <= n_fblk;
        r_fcnt    <= n_fcnt;
        r_off_en  <= n_off_en;
        r_prod    <= n_prod;
        r_offset  <= n_offset;
    end

    assign o_busy         = r_state != bsa_pkg::ST_IDLE;
    assign o_valid        = r_valid;
    assign o_status       = r_status;
    assign o_out_index    = r_out_idx;
    assign o_block_number = r_blk;
    assign o_block_count  = 5'(r_cnt);
    assign o_byte_offset  = r_offset;
    assign o_pad_bytes    = r_pad;
    assign o_freed_valid  = r_fv;
    assign o_freed_block  = r_fblk;
    assign o_freed_count  = 5'(r_fcnt);

    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fl_req.push |-> !fl_stat.push_full)
        else $error("push onto a full free list");

    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fl_req.pop |-> !fl_stat.pop_empty)
        else $error("pop from an empty free list");

    a_valid_after_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == bsa_pkg::ST_ADD))
        else $error("result strobe outside the offset stage");

    a_next_slot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == bsa_pkg::ST_DECIDE |=> r_next_slot <= NSW'(MAX_SLOTS))
        else $error("slot counter beyond table size");

    a_no_slot_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == bsa_pkg::ST_IDLE |-> !slot_we && !fl_req.push && !fl_req.pop)
        else $error("table update while idle");

endmodule

FILE: rtl/bsa_div.sv
// Restoring divider, one quotient bit per cycle.
module bsa_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [14:0] i_divisor,
    output logic        o_done,
    output logic [31:0] o_quo,
    output logic [14:0] o_rem
);

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [31:0] r_quo;
    logic [14:0] r_rem;
    logic [14:0] r_dvs;

    logic [15:0] t_try;
    logic        ge;

    assign t_try = {r_rem, r_quo[31]};
    assign ge    = t_try >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= ge ? 15'(t_try - {1'b0, r_dvs}) : t_try[14:0];
                r_quo <= {r_quo[30:0], ge};
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

FILE: rtl/bsa_slot_ram.sv
// Slot table memory: one write port, one registered read port.
module bsa_slot_ram #(
    parameter int AW = 8,
    parameter int DW = 22
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] mem [2**AW];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/bsa_free_list.sv
// Per-size FIFO free lists: run memory plus head and fill counters.
module bsa_free_list #(
    parameter int MAX_RUN_BLOCKS = bsa_pkg::MAX_RUN_BLOCKS_DEF,
    parameter int FREE_PER_SIZE  = bsa_pkg::FREE_PER_SIZE_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bsa_pkg::t_fl_req  i_req,
    output bsa_pkg::t_fl_stat o_stat,
    output logic [15:0]       o_pop_blk
);

    localparam int LW = (MAX_RUN_BLOCKS > 1) ? $clog2(MAX_RUN_BLOCKS) : 1;
    localparam int PW = $clog2(FREE_PER_SIZE);
    localparam int FW = $clog2(FREE_PER_SIZE + 1);

    logic [15:0]   mem [2**(LW+PW)];
    logic [PW-1:0] r_head [MAX_RUN_BLOCKS];
    logic [FW-1:0] r_fill [MAX_RUN_BLOCKS];
    logic [15:0]   r_q;

    logic [LW-1:0] pl;
    logic [LW-1:0] ol;
    logic [PW+1:0] pos_sum;
    logic [PW-1:0] pos;

    assign pl      = LW'(i_req.push_lst);
    assign ol      = LW'(i_req.pop_lst);
    assign pos_sum = (PW+2)'(r_head[pl]) + (PW+2)'(r_fill[pl]);
    assign pos     = (pos_sum >= (PW+2)'(FREE_PER_SIZE)) ?
                     PW'(pos_sum - (PW+2)'(FREE_PER_SIZE)) : PW'(pos_sum);

    assign o_stat.push_full = r_fill[pl] >= FW'(FREE_PER_SIZE);
    assign o_stat.pop_empty = r_fill[ol] == '0;

    always_ff @(posedge i_clk) begin
        if (i_req.push) begin
            mem[{pl, pos}] <= i_req.push_blk;
        end
        r_q <= mem[{ol, r_head[ol]}];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_RUN_BLOCKS; i++) begin
                r_head[i] <= '0;
                r_fill[i] <= '0;
            end
        end else begin
            if (i_req.push) begin
                r_fill[pl] <= r_fill[pl] + FW'(1);
            end
            if (i_req.pop) begin
                r_head[ol] <= (r_head[ol] == PW'(FREE_PER_SIZE - 1)) ? '0 :
                              r_head[ol] + PW'(1);
                r_fill[ol] <= r_fill[ol] - FW'(1);
            end
        end
    end

    assign o_pop_blk = r_q;

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for the block slot allocator top level.
`timescale 1ns / 100ps

module testbench;

    localparam int NSLOT = 256;
    localparam int NRUN = 16;
    localparam int NFREE = 32;
    localparam int CYCLE_LIMIT = 600000;

    typedef struct {
        logic [2:0]         op;
        logic               given;
        logic [7:0]         idx;
        logic signed [15:0] len;
        logic [31:0]        fsize;
    } t_cmd;

    typedef struct {
        logic [2:0]  status;
        logic [7:0]  idx;
        logic [15:0] blk;
        logic [4:0]  cnt;
        logic [31:0] off;
        logic [13:0] pad;
        logic        fv;
        logic [15:0] fb;
        logic [4:0]  fc;
    } t_alloc_res;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_start = 1'b0;
    logic [2:0]         i_opcode = '0;
    logic               i_index_given = 1'b0;
    logic [7:0]         i_slot_index = '0;
    logic signed [15:0] i_length = '0;
    logic [31:0]        i_file_size = '0;
    logic               i_cfg_we = 1'b0;
    logic               i_cfg_addr = 1'b0;
    logic [15:0]        i_cfg_data = '0;
    logic               o_busy, o_valid, o_freed_valid;
    logic [2:0]         o_status;
    logic [7:0]         o_out_index;
    logic [15:0]        o_block_number, o_freed_block;
    logic [4:0]         o_block_count, o_freed_count;
    logic [31:0]        o_byte_offset;
    logic [13:0]        o_pad_bytes;

    block_slot_allocator_top dut (.*);

    // allocator shadow state
    int unsigned m_bsize, m_hdr;
    bit          m_valid [NSLOT];
    logic [15:0] m_start [NSLOT];
    logic [4:0]  m_nblk [NSLOT];
    logic [15:0] m_runs [NRUN][NFREE];
    int          m_head [NRUN];
    int          m_fill [NRUN];
    int          m_next;
    logic [15:0] m_scan, m_end;

    t_cmd       cmd_q [$];
    t_alloc_res due_q [$];
    t_cmd       cur;
    int         errors = 0;
    int         cycles = 0;
    int         burst_left = 0, gap_left = 0;

    initial forever #10 i_clk = ~i_clk;

    function automatic int unsigned eff_bs();
        return (m_bsize == 0) ? 1 : m_bsize;
    endfunction

    function automatic logic [31:0] offset_for(logic [15:0] blk);
        longint unsigned v;
        v = longint'(m_hdr) + longint'(blk) * longint'(eff_bs());
        return v[31:0];
    endfunction

    function automatic bit run_push(int unsigned size, logic [15:0] blk);
        int s;
        s = size - 1;
        if (m_fill[s] >= NFREE) return 0;
        m_runs[s][(m_head[s] + m_fill[s]) % NFREE] = blk;
        m_fill[s]++;
        return 1;
    endfunction

    task automatic release_run(input int idx, inout t_alloc_res r, output bit ok);
        ok = run_push(m_nblk[idx], m_start[idx]);
        if (ok) begin
            m_valid[idx] = 0;
            r.fv = 1;
            r.fb = m_start[idx];
            r.fc = m_nblk[idx];
        end
    endtask

    task automatic clear_slot(input int idx, inout t_alloc_res r);
        bit ok;
        if (!m_valid[idx]) begin
            r.status = bsa_pkg::STAT_NOT_FOUND;
            return;
        end
        release_run(idx, r, ok);
        if (!ok) begin
            r.status = bsa_pkg::STAT_LIST_FULL;
            return;
        end
        r.blk = r.fb;
        r.cnt = r.fc;
        r.off = offset_for(r.fb);
    endtask

    task automatic put_slot(input t_cmd c, inout t_alloc_res r);
        int          len, idx, s;
        int unsigned cnt, rem;
        logic [15:0] blk;
        bit          ok;
        len = c.len;
        idx = c.idx;
        if (len == 0) begin
            if (c.given) clear_slot(idx, r);
            else r.status = bsa_pkg::STAT_NOT_FOUND;
            return;
        end
        if (len < 0) begin
            r.status = bsa_pkg::STAT_TOO_LONG;
            return;
        end
        cnt = (len + bsa_pkg::REC_HDR - 1) / eff_bs() + 1;
        if (cnt > NRUN) begin
            r.status = bsa_pkg::STAT_TOO_LONG;
            return;
        end
        if (c.given) begin
            if (!m_valid[idx]) begin
                r.status = bsa_pkg::STAT_NOT_FOUND;
                return;
            end
            if (m_nblk[idx] == cnt) begin
                blk = m_start[idx];
            end else begin
                release_run(idx, r, ok);
                if (!ok) begin
                    r.status = bsa_pkg::STAT_LIST_FULL;
                    return;
                end
            end
        end else begin
            if (m_next >= NSLOT) begin
                r.idx = m_next[7:0];
                r.status = bsa_pkg::STAT_TABLE_FULL;
                return;
            end
            idx = m_next;
            m_next++;
        end
        if (!(c.given && m_nblk[idx] == cnt && m_valid[idx])) begin
            s = cnt - 1;
            if (m_fill[s] > 0) begin
                blk = m_runs[s][m_head[s]];
                m_head[s] = (m_head[s] + 1) % NFREE;
                m_fill[s]--;
            end else begin
                blk = m_end;
                m_end = m_end + cnt[15:0];
            end
            m_valid[idx] = 1;
            m_start[idx] = blk;
            m_nblk[idx] = cnt[4:0];
        end
        rem = (len + bsa_pkg::REC_HDR) % eff_bs();
        r.idx = idx[7:0];
        r.blk = blk;
        r.cnt = cnt[4:0];
        r.off = offset_for(blk);
        r.pad = (rem != 0) ? 14'(eff_bs() - rem) : '0;
    endtask

    task automatic predict_alloc(input t_cmd c, output t_alloc_res r);
        int          len;
        int unsigned cnt, rem, q;
        r = '{default: '0};
        len = c.len;
        case (c.op)
            bsa_pkg::OP_RESTART: m_scan = '0;
            bsa_pkg::OP_SCAN: begin
                r.blk = m_scan;
                r.off = offset_for(m_scan);
                if (len >= 0) begin
                    cnt = (len + bsa_pkg::REC_HDR - 1) / eff_bs() + 1;
                    rem = (len + bsa_pkg::REC_HDR) % eff_bs();
                    r.idx = m_next[7:0];
                    r.pad = (rem != 0) ? 14'(eff_bs() - rem) : '0;
                    if (cnt > NRUN) begin
                        r.status = bsa_pkg::STAT_TOO_LONG;
                        if (m_next < NSLOT) m_next++;
                    end else if (m_next >= NSLOT) begin
                        r.status = bsa_pkg::STAT_TABLE_FULL;
                        r.cnt = cnt[4:0];
                    end else begin
                        m_valid[m_next] = 1;
                        m_start[m_next] = m_scan;
                        m_nblk[m_next] = cnt[4:0];
                        m_next++;
                        r.cnt = cnt[4:0];
                    end
                end else begin
                    cnt = -len;
                    if (cnt > NRUN) begin
                        r.status = bsa_pkg::STAT_TOO_LONG;
                    end else begin
                        r.cnt = cnt[4:0];
                        if (!run_push(cnt, m_scan)) r.status = bsa_pkg::STAT_LIST_FULL;
                    end
                end
                m_scan = m_scan + cnt[15:0];
            end
            bsa_pkg::OP_OPEN: begin
                if (c.fsize >= m_hdr) begin
                    q = (c.fsize - m_hdr) / eff_bs();
                    m_end = (q > 32'hFFFF) ? 16'hFFFF : q[15:0];
                end else begin
                    m_end = '0;
                end
                r.blk = m_end;
                r.off = offset_for(m_end);
            end
            bsa_pkg::OP_PUT: begin
                r.idx = c.idx;
                put_slot(c, r);
            end
            bsa_pkg::OP_CLEAR: begin
                r.idx = c.idx;
                clear_slot(c.idx, r);
            end
            default: ;
        endcase
    endtask

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    // driver: bursts of items separated by random gaps
    always @(posedge i_clk) begin
        t_alloc_res r;
        if (!(i_start && o_busy)) begin
            if (i_start) begin
                predict_alloc(cur, r);
                due_q.push_back(r);
            end
            if (gap_left > 0 || !i_rst_n) begin
                gap_left <= gap_left - (gap_left > 0);
                i_start <= 1'b0;
            end else if (cmd_q.size() > 0) begin
                cur = cmd_q.pop_front();
                i_opcode <= cur.op;
                i_index_given <= cur.given;
                i_slot_index <= cur.idx;
                i_length <= cur.len;
                i_file_size <= cur.fsize;
                i_start <= 1'b1;
                if (burst_left > 0) begin
                    burst_left <= burst_left - 1;
                end else begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
                end
            end else begin
                i_start <= 1'b0;
            end
        end
    end

    // monitor: every strobed result is taken
    always @(posedge i_clk) begin
        t_alloc_res e;
        cycles <= cycles + 1;
        if (o_valid) begin
            if (due_q.size() == 0) begin
                report("unexpected result", 1, 0);
            end else begin
                e = due_q.pop_front();
                if (o_status !== e.status) report("status", o_status, e.status);
                if (o_out_index !== e.idx) report("out_index", o_out_index, e.idx);
                if (o_block_number !== e.blk) report("block_number", o_block_number, e.blk);
                if (o_block_count !== e.cnt) report("block_count", o_block_count, e.cnt);
                if (o_byte_offset !== e.off) report("byte_offset", o_byte_offset, e.off);
                if (o_pad_bytes !== e.pad) report("pad_bytes", o_pad_bytes, e.pad);
                if (o_freed_valid !== e.fv) report("freed_valid", o_freed_valid, e.fv);
                if (o_freed_block !== e.fb) report("freed_block", o_freed_block, e.fb);
                if (o_freed_count !== e.fc) report("freed_count", o_freed_count, e.fc);
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout at cycle %0d", cycles);
            $display("block_slot_allocator_top test failed");
            $finish;
        end
    end

    task automatic add_cmd(input logic [2:0] op, input logic given, input logic [7:0] idx,
                           input logic [15:0] len, input logic [31:0] fsize);
        t_cmd c;
        c.op = op;
        c.given = given;
        c.idx = idx;
        c.len = len;
        c.fsize = fsize;
        cmd_q.push_back(c);
    endtask

    task automatic write_cfg(input logic addr, input logic [15:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= data;
        if (addr == bsa_pkg::CFG_BLOCK_SIZE) m_bsize = data[14:0];
        else m_hdr = data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // hold until every queued item has been taken and answered
    task automatic drain();
        while (cmd_q.size() > 0 || i_start || due_q.size() > 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_len();
        int unsigned top;
        top = 16 * eff_bs();
        case ($urandom_range(0, 9))
            0: return 16'($urandom());
            1: return 16'(-$urandom_range(1, 20));
            default: return (top > 4) ? 16'($urandom_range(1, top - 4))
                                      : 16'($urandom_range(1, 12));
        endcase
    endfunction

    task automatic random_items(input int n);
        int          k, sel;
        logic [7:0]  idx;
        for (k = 0; k < n; k++) begin
            sel = $urandom_range(0, 99);
            idx = ($urandom_range(0, 3) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 40));
            if (sel < 4) add_cmd(bsa_pkg::OP_RESTART, 1'($urandom()), 8'($urandom()),
                                 16'($urandom()), $urandom());
            else if (sel < 22) add_cmd(bsa_pkg::OP_SCAN, 1'($urandom()), 8'($urandom()),
                                       pick_len(), $urandom());
            else if (sel < 27) add_cmd(bsa_pkg::OP_OPEN, 1'($urandom()), 8'($urandom()),
                                       16'($urandom()),
                                       ($urandom_range(0, 3) == 0) ? $urandom()
                                                                   : $urandom_range(0, 200000));
            else if (sel < 80) add_cmd(bsa_pkg::OP_PUT, $urandom_range(0, 9) < 7, idx,
                                       ($urandom_range(0, 15) == 0) ? 16'd0 : pick_len(),
                                       $urandom());
            else if (sel < 97) add_cmd(bsa_pkg::OP_CLEAR, 1'($urandom()), idx,
                                       16'($urandom()), $urandom());
            else add_cmd(3'($urandom_range(5, 7)), 1'($urandom()), 8'($urandom()),
                         16'($urandom()), $urandom());
        end
    endtask

    initial begin
        int p;
        m_bsize = bsa_pkg::BLOCK_SIZE_RST;
        m_hdr = bsa_pkg::HEADER_RST;
        m_next = 0;
        m_scan = '0;
        m_end = '0;
        for (p = 0; p < NSLOT; p++) m_valid[p] = 0;
        for (p = 0; p < NRUN; p++) begin
            m_head[p] = 0;
            m_fill[p] = 0;
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: restart, scan, open, put and clear cases, ignored codes
        add_cmd(bsa_pkg::OP_RESTART, 0, 0, 0, 0);
        add_cmd(bsa_pkg::OP_SCAN, 0, 0, 16'd100, 0);
        add_cmd(bsa_pkg::OP_SCAN, 0, 0, 16'd0, 0);
        add_cmd(bsa_pkg::OP_SCAN, 0, 0, 16'sd16384, 0);
        add_cmd(bsa_pkg::OP_SCAN, 0, 0, -16'sd3, 0);
        add_cmd(bsa_pkg::OP_SCAN, 0, 0, -16'sd16384, 0);
        add_cmd(bsa_pkg::OP_SCAN, 0, 0, 16'h7FFF, 0);
        add_cmd(bsa_pkg::OP_OPEN, 0, 0, 0, 32'd4);
        add_cmd(bsa_pkg::OP_OPEN, 0, 0, 0, 32'hFFFF_FFFF);
        add_cmd(bsa_pkg::OP_OPEN, 0, 0, 0, 32'd2000);
        add_cmd(bsa_pkg::OP_PUT, 0, 8'hFF, 16'd124, 32'hFFFF_FFFF);
        add_cmd(bsa_pkg::OP_PUT, 1, 8'd0, 16'd120, 0);
        add_cmd(bsa_pkg::OP_PUT, 1, 8'd0, 16'd500, 0);
        add_cmd(bsa_pkg::OP_PUT, 0, 0, 16'd300, 0);
        add_cmd(bsa_pkg::OP_PUT, 1, 8'd1, 16'd0, 0);
        add_cmd(bsa_pkg::OP_PUT, 0, 8'd1, 16'd0, 0);
        add_cmd(bsa_pkg::OP_PUT, 1, 8'd2, -16'sd5, 0);
        add_cmd(bsa_pkg::OP_PUT, 1, 8'd2, 16'sd16384, 0);
        add_cmd(bsa_pkg::OP_PUT, 1, 8'd200, 16'd10, 0);
        add_cmd(bsa_pkg::OP_CLEAR, 0, 8'd2, 0, 0);
        add_cmd(bsa_pkg::OP_CLEAR, 1, 8'd2, 0, 0);
        add_cmd(bsa_pkg::OP_CLEAR, 0, 8'd255, 0, 0);
        add_cmd(3'd5, 1, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF);
        add_cmd(3'd7, 0, 0, 0, 0);
        drain();

        random_items(120);
        drain();
        write_cfg(bsa_pkg::CFG_BLOCK_SIZE, 16'd1);
        write_cfg(bsa_pkg::CFG_HEADER, 16'd0);
        random_items(110);
        drain();
        write_cfg(bsa_pkg::CFG_BLOCK_SIZE, 16'd16384);
        write_cfg(bsa_pkg::CFG_HEADER, 16'hFFFF);
        random_items(110);
        drain();
        write_cfg(bsa_pkg::CFG_BLOCK_SIZE, 16'h8000);   // zero block size behaves as one
        random_items(90);
        drain();
        write_cfg(bsa_pkg::CFG_BLOCK_SIZE, 16'($urandom_range(2, 600)) | 16'h8000);
        write_cfg(bsa_pkg::CFG_HEADER, 16'($urandom()));
        random_items(130);
        drain();
        write_cfg(bsa_pkg::CFG_BLOCK_SIZE, 16'h7FFF);
        write_cfg(bsa_pkg::CFG_HEADER, 16'd16);
        random_items(60);
        drain();
        write_cfg(bsa_pkg::CFG_BLOCK_SIZE, 16'd64);
        random_items(80);
        drain();

        if (errors == 0) begin
            $display("block_slot_allocator_top test passed");
        end else begin
            $display("block_slot_allocator_top test failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/bsa_pkg.sv
rtl/bsa_div.sv
rtl/bsa_slot_ram.sv
rtl/bsa_free_list.sv
rtl/block_slot_allocator_top.sv
dv/testbench.sv
